[rtl/wpss_pkg.sv]
// Package for the weighted parity subset search unit.
// Holds sizes, register indexes, FSM state type and shared structs; no dependencies.
package wpss_pkg;

  // Fixed sizes of the item fields
  localparam int FEAT_W    = 16;
  localparam int IDX_W     = 4;
  localparam int SIZE_W    = 2;
  localparam int MAG_OUT_W = 24;

  // Feature and degree limits
  localparam int FEATURES   = 16;
  localparam int MAX_DEGREE = 3;
  localparam int N_W        = $clog2(FEATURES + 1);

  // Defaults for top-level parameters
  localparam int EXAMPLES_DEF    = 256;
  localparam int WEIGHT_BITS_DEF = 16;

  // Configuration port
  localparam int FC_W       = 5;
  localparam int MD_W       = 2;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEGREE    = 1'b1;

  localparam logic [FC_W-1:0] FC_RESET = 5'd16;
  localparam logic [MD_W-1:0] MD_RESET = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_CMP,
    ST_OUT
  } wpss_state_e;

  // One feature subset: size and up to three indices
  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  a;
    logic [IDX_W-1:0]  b;
    logic [IDX_W-1:0]  c;
  } wpss_subset_t;

  // Control of the shared accumulator
  typedef struct packed {
    logic new_search;  // forget the best so far
    logic clr;         // clear running sum
    logic add;         // fold in one term
    logic sub;         // term is negative
    logic judge;       // compare running sum with best
  } wpss_acc_ctrl_t;

endpackage

[rtl/wpss_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wpss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[rtl/wpss_subset.sv]
// Subset enumerator: walks sizes 1..deg, each in lexicographic order.
// Depends on wpss_pkg.
module wpss_subset (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            step_i,
  input  logic [wpss_pkg::N_W-1:0]        n_i,
  input  logic [wpss_pkg::SIZE_W-1:0]     deg_i,
  output wpss_pkg::wpss_subset_t          subset_o,
  output logic                            done_o
);

  wpss_pkg::wpss_subset_t sub_q, sub_d, nxt;
  logic                   nxt_none;
  logic [wpss_pkg::N_W-1:0] a5, b5, c5;
  logic                   ok2, ok3;

  assign a5 = wpss_pkg::N_W'(sub_q.a);
  assign b5 = wpss_pkg::N_W'(sub_q.b);
  assign c5 = wpss_pkg::N_W'(sub_q.c);

  // A size has subsets only if allowed by degree and enough features exist
  assign ok2 = (deg_i >= 2'd2) && (n_i >= wpss_pkg::N_W'(2));
  assign ok3 = (deg_i == 2'd3) && (n_i >= wpss_pkg::N_W'(3));

  always_comb begin
    nxt      = sub_q;
    nxt_none = 1'b0;
    unique case (sub_q.size)
      2'd1: begin
        if (a5 + wpss_pkg::N_W'(1) < n_i) begin
          nxt.a = sub_q.a + 1'b1;
        end else if (ok2) begin
          nxt = '{size: 2'd2, a: '0, b: wpss_pkg::IDX_W'(1), c: '0};
        end else begin
          nxt_none = 1'b1;
        end
      end
      2'd2: begin
        if (b5 + wpss_pkg::N_W'(1) < n_i) begin
          nxt.b = sub_q.b + 1'b1;
        end else if (a5 + wpss_pkg::N_W'(2) < n_i) begin
          nxt.a = sub_q.a + 1'b1;
          nxt.b = sub_q.a + wpss_pkg::IDX_W'(2);
        end else if (ok3) begin
          nxt = '{size: 2'd3, a: '0, b: wpss_pkg::IDX_W'(1), c: wpss_pkg::IDX_W'(2)};
        end else begin
          nxt_none = 1'b1;
        end
      end
      2'd3: begin
        if (c5 + wpss_pkg::N_W'(1) < n_i) begin
          nxt.c = sub_q.c + 1'b1;
        end else if (b5 + wpss_pkg::N_W'(2) < n_i) begin
          nxt.b = sub_q.b + 1'b1;
          nxt.c = sub_q.b + wpss_pkg::IDX_W'(2);
        end else if (a5 + wpss_pkg::N_W'(3) < n_i) begin
          nxt.a = sub_q.a + 1'b1;
          nxt.b = sub_q.a + wpss_pkg::IDX_W'(2);
          nxt.c = sub_q.a + wpss_pkg::IDX_W'(3);
        end else begin
          nxt_none = 1'b1;
        end
      end
      default: begin
        nxt_none = 1'b1;
      end
    endcase
  end

  always_comb begin
    sub_d = sub_q;
    if (start_i) begin
      sub_d = '{size: 2'd1, a: '0, b: '0, c: '0};
    end else if (step_i && !nxt_none) begin
      sub_d = nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '{size: 2'd1, a: '0, b: '0, c: '0};
    end else begin
      sub_q <= sub_d;
    end
  end

  assign subset_o = sub_q;
  assign done_o   = nxt_none;

endmodule

[rtl/wpss_accum.sv]
// Shared add/subtract accumulator with best-magnitude tracking.
// Depends on wpss_pkg.
module wpss_accum #(
  parameter int WEIGHT_BITS = wpss_pkg::WEIGHT_BITS_DEF,
  parameter int MAG_W       = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wpss_pkg::wpss_acc_ctrl_t ctrl_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  output logic                   take_o,
  output logic [MAG_W-1:0]       best_o
);

  localparam int ACC_W = MAG_W + 1;

  logic signed [ACC_W-1:0] acc_q, acc_d, term;
  logic        [MAG_W-1:0] best_q, best_d, mag;
  logic                    have_q, have_d;

  assign term = ctrl_i.sub ? -$signed(ACC_W'(weight_i)) : $signed(ACC_W'(weight_i));

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.add) begin
      acc_d = acc_q + term;
    end
  end

  // Magnitude fits MAG_W bits by construction
  assign mag    = acc_q[ACC_W-1] ? MAG_W'(-acc_q) : MAG_W'(acc_q);
  assign take_o = ctrl_i.judge && (!have_q || (mag > best_q));

  always_comb begin
    best_d = best_q;
    have_d = have_q;
    if (ctrl_i.new_search) begin
      best_d = '0;
      have_d = 1'b0;
    end else if (take_o) begin
      best_d = mag;
      have_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      best_q <= '0;
      have_q <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      best_q <= best_d;
      have_q <= have_d;
    end
  end

  assign best_o = best_q;

endmodule

[rtl/weighted_parity_subset_search_unit.sv]
// Top level of the weighted parity subset search unit.
// Depends on wpss_pkg, wpss_ram, wpss_subset, wpss_accum.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------------------
//  in       | in        | in_valid_i / in_ready_o  | feature_bits, label, weight, last
//  out      | out       | out_valid_o / out_ready_i| subset_size, feature_first/second/
//           |           |                          | third, best_magnitude
//  cfg      | in        | cfg_we_i (no wait)       | cfg_index_i, cfg_wdata_i
//
// Loading: one example item per cycle while idle; it goes to the example RAM.
// Search (after an item with last set): one shared accumulator walks the stored
// examples for every subset, one RAM read per cycle; then the last read data is
// added, the walk is seen done and a compare state judges the sum (at most 696
// subsets), then the result waits in the output stage until taken. No item is
// accepted during search or while the result waits. Reset clears control state
// only; the example RAM needs no clearing since only entries below the count are
// read.
module weighted_parity_subset_search_unit #(
  parameter int EXAMPLES    = wpss_pkg::EXAMPLES_DEF,
  parameter int WEIGHT_BITS = wpss_pkg::WEIGHT_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // example items
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [wpss_pkg::FEAT_W-1:0]         feature_bits_i,
  input  logic                                label_i,
  input  logic [15:0]                         weight_i,
  input  logic                                last_i,
  // result items
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [wpss_pkg::SIZE_W-1:0]         subset_size_o,
  output logic [wpss_pkg::IDX_W-1:0]          feature_first_o,
  output logic [wpss_pkg::IDX_W-1:0]          feature_second_o,
  output logic [wpss_pkg::IDX_W-1:0]          feature_third_o,
  output logic [wpss_pkg::MAG_OUT_W-1:0]      best_magnitude_o,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [wpss_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wpss_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int CNT_W   = $clog2(EXAMPLES + 1);
  localparam int ADDR_W  = (EXAMPLES > 1) ? $clog2(EXAMPLES) : 1;
  localparam int MAG_W   = $clog2(EXAMPLES) + WEIGHT_BITS;
  localparam int ENTRY_W = wpss_pkg::FEAT_W + 1 + WEIGHT_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [wpss_pkg::FC_W-1:0] fc_q;
  logic [wpss_pkg::MD_W-1:0] md_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= wpss_pkg::FC_RESET;
      md_q <= wpss_pkg::MD_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wpss_pkg::CFG_FEATURE_COUNT: fc_q <= cfg_wdata_i;
        wpss_pkg::CFG_MAX_DEGREE:    fc_q <= fc_q;
        default:                     fc_q <= fc_q;
      endcase
      if (cfg_index_i == wpss_pkg::CFG_MAX_DEGREE) begin
        md_q <= wpss_pkg::MD_W'(cfg_wdata_i);
      end
    end
  end

  // Effective feature count and degree: zero means one, saturate at the limits
  logic [wpss_pkg::N_W-1:0]    n_eff;
  logic [wpss_pkg::SIZE_W-1:0] deg_eff;

  always_comb begin
    priority if (fc_q == '0) begin
      n_eff = wpss_pkg::N_W'(1);
    end else if (wpss_pkg::N_W'(fc_q) > wpss_pkg::N_W'(wpss_pkg::FEATURES)) begin
      n_eff = wpss_pkg::N_W'(wpss_pkg::FEATURES);
    end else begin
      n_eff = wpss_pkg::N_W'(fc_q);
    end
  end

  always_comb begin
    priority if (md_q == '0) begin
      deg_eff = wpss_pkg::SIZE_W'(1);
    end else if (md_q > wpss_pkg::SIZE_W'(wpss_pkg::MAX_DEGREE)) begin
      deg_eff = wpss_pkg::SIZE_W'(wpss_pkg::MAX_DEGREE);
    end else begin
      deg_eff = md_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  wpss_pkg::wpss_state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;   // stored examples
  logic [CNT_W-1:0] idx_q, idx_d;       // next example to read
  logic             rd_vld_q;           // read data valid this cycle
  logic             in_fire, out_fire, start, rd_en, wr_en;
  logic             sum_done, enum_done, enum_step;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign start    = in_fire && last_i;
  assign wr_en    = in_fire && (count_q < CNT_W'(EXAMPLES));
  assign sum_done = (idx_q == count_q) && !rd_vld_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wpss_pkg::ST_IDLE: if (start)       state_d = wpss_pkg::ST_SUM;
      wpss_pkg::ST_SUM:  if (sum_done)    state_d = wpss_pkg::ST_CMP;
      wpss_pkg::ST_CMP:  state_d = enum_done ? wpss_pkg::ST_OUT : wpss_pkg::ST_SUM;
      wpss_pkg::ST_OUT:  if (out_ready_i) state_d = wpss_pkg::ST_IDLE;
      default:           state_d = wpss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    rd_en       = 1'b0;
    enum_step   = 1'b0;
    unique case (state_q)
      wpss_pkg::ST_IDLE: in_ready_o  = 1'b1;
      wpss_pkg::ST_SUM:  rd_en       = (idx_q < count_q);
      wpss_pkg::ST_CMP:  enum_step   = !enum_done;
      wpss_pkg::ST_OUT:  out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (out_fire) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + 1'b1;
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (start || (state_q == wpss_pkg::ST_CMP)) begin
      idx_d = '0;
    end else if (rd_en) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wpss_pkg::ST_IDLE;
      count_q  <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      idx_q    <= idx_d;
      rd_vld_q <= rd_en;
    end
  end

  // ---------------------------------------------------------------------------
  // Example store: {features, label, weight}
  // ---------------------------------------------------------------------------
  logic [ENTRY_W-1:0] rdata;

  wpss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (EXAMPLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({feature_bits_i, label_i, WEIGHT_BITS'(weight_i)}),
    .re_i    (rd_en),
    .raddr_i (idx_q[ADDR_W-1:0]),
    .rdata_o (rdata)
  );

  logic [wpss_pkg::FEAT_W-1:0] rd_feat;
  logic                        rd_label;
  logic [WEIGHT_BITS-1:0]      rd_weight;

  assign rd_feat   = rdata[ENTRY_W-1 -: wpss_pkg::FEAT_W];
  assign rd_label  = rdata[WEIGHT_BITS];
  assign rd_weight = rdata[WEIGHT_BITS-1:0];

  // ---------------------------------------------------------------------------
  // Subset walk
  // ---------------------------------------------------------------------------
  wpss_pkg::wpss_subset_t cur;

  wpss_subset u_subset (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .step_i   (enum_step),
    .n_i      (n_eff),
    .deg_i    (deg_eff),
    .subset_o (cur),
    .done_o   (enum_done)
  );

  // Term is negative when the count of zeros among label and chosen bits is odd
  logic neg;
  assign neg = ~rd_label ^ ~rd_feat[cur.a]
             ^ ((cur.size >= 2'd2) & ~rd_feat[cur.b])
             ^ ((cur.size == 2'd3) & ~rd_feat[cur.c]);

  wpss_pkg::wpss_acc_ctrl_t acc_ctrl;
  logic                     take;
  logic [MAG_W-1:0]         best_mag;

  assign acc_ctrl.new_search = start;
  assign acc_ctrl.clr        = start || (state_q == wpss_pkg::ST_CMP);
  assign acc_ctrl.add        = rd_vld_q;
  assign acc_ctrl.sub        = neg;
  assign acc_ctrl.judge      = (state_q == wpss_pkg::ST_CMP);

  wpss_accum #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .MAG_W       (MAG_W)
  ) u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .weight_i (rd_weight),
    .take_o   (take),
    .best_o   (best_mag)
  );

  // Best subset so far; held as the result while waiting on the output side
  wpss_pkg::wpss_subset_t best_sub_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_sub_q <= '0;
    end else if (take) begin
      best_sub_q <= cur;
    end
  end

  assign subset_size_o    = best_sub_q.size;
  assign feature_first_o  = best_sub_q.a;
  assign feature_second_o = best_sub_q.b;
  assign feature_third_o  = best_sub_q.c;
  assign best_magnitude_o = wpss_pkg::MAG_OUT_W'(best_mag);

endmodule

[sim/wpss_result_checker.sv]
`timescale 1ns / 1ps
// Result checker for the weighted parity subset search unit testbench.
// Mirrors the example store and the subset search from the channel traffic; uses wpss_pkg.
module wpss_result_checker
  import wpss_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [FEAT_W-1:0]    feature_bits_i,
  input  logic                 label_i,
  input  logic [15:0]          weight_i,
  input  logic                 last_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [SIZE_W-1:0]    subset_size_i,
  input  logic [IDX_W-1:0]     feature_first_i,
  input  logic [IDX_W-1:0]     feature_second_i,
  input  logic [IDX_W-1:0]     feature_third_i,
  input  logic [MAG_OUT_W-1:0] best_magnitude_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);

  localparam int STORE_DEPTH = EXAMPLES_DEF;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic [SIZE_W-1:0]    size;
    logic [IDX_W-1:0]     first;
    logic [IDX_W-1:0]     second;
    logic [IDX_W-1:0]     third;
    logic [MAG_OUT_W-1:0] mag;
  } winner_t;

  logic [FEAT_W-1:0] feat_mem   [STORE_DEPTH];
  logic              label_mem  [STORE_DEPTH];
  logic [15:0]       weight_mem [STORE_DEPTH];
  int unsigned       n_stored;
  logic [FC_W-1:0]   fc_reg;
  logic [MD_W-1:0]   md_reg;
  winner_t           winners_q [$];
  int                errors;

  // signed sum of weights; a term is negative when the zero count is odd
  function automatic longint parity_sum(int d, int a, int b, int c);
    longint sum;
    int     zeros;
    sum = 0;
    for (int i = 0; i < n_stored; i++) begin
      zeros = label_mem[i] ? 0 : 1;
      zeros += !feat_mem[i][a];
      if (d >= 2) zeros += !feat_mem[i][b];
      if (d >= 3) zeros += !feat_mem[i][c];
      if (zeros[0]) sum -= weight_mem[i];
      else sum += weight_mem[i];
    end
    return sum;
  endfunction

  // first subset with the strictly largest magnitude, sizes ascending
  function automatic winner_t best_subset();
    winner_t w;
    longint  s;
    longint  mag;
    longint  best;
    int      n;
    int      deg;
    bit      have;
    n = (fc_reg == 0) ? 1 : ((fc_reg > FEATURES) ? FEATURES : int'(fc_reg));
    deg = (md_reg == 0) ? 1 : int'(md_reg);
    if (deg > MAX_DEGREE) deg = MAX_DEGREE;
    if (deg > 3) deg = 3;
    have = 1'b0;
    best = 0;
    w = '0;
    for (int d = 1; d <= deg; d++)
      for (int a = 0; a < n; a++)
        for (int b = (d >= 2) ? a + 1 : 0; b < ((d >= 2) ? n : 1); b++)
          for (int c = (d >= 3) ? b + 1 : 0; c < ((d >= 3) ? n : 1); c++) begin
            s = parity_sum(d, a, b, c);
            mag = (s < 0) ? -s : s;
            if (!have || mag > best) begin
              have = 1'b1;
              best = mag;
              w.size = d[SIZE_W-1:0];
              w.first = a[IDX_W-1:0];
              w.second = b[IDX_W-1:0];
              w.third = c[IDX_W-1:0];
            end
          end
    w.mag = best[MAG_OUT_W-1:0];
    return w;
  endfunction

  function automatic void note_failure(string msg);
    errors++;
    if (errors <= REPORT_MAX) $display("%t: %s", $realtime, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    winner_t exp_w;
    winner_t got_w;
    if (!rst_ni) begin
      n_stored = 0;
      fc_reg = FC_RESET;
      md_reg = MD_RESET;
      winners_q.delete();
      errors = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got_w = '{subset_size_i, feature_first_i, feature_second_i, feature_third_i,
                  best_magnitude_i};
        if (winners_q.size() == 0) begin
          note_failure($sformatf("unexpected result: size %0d idx %0d/%0d/%0d mag %0d",
                                 got_w.size, got_w.first, got_w.second, got_w.third,
                                 got_w.mag));
        end else begin
          exp_w = winners_q.pop_front();
          if (got_w !== exp_w)
            note_failure({
              $sformatf("result mismatch: exp size %0d idx %0d/%0d/%0d mag %0d",
                        exp_w.size, exp_w.first, exp_w.second, exp_w.third, exp_w.mag),
              $sformatf(", got size %0d idx %0d/%0d/%0d mag %0d",
                        got_w.size, got_w.first, got_w.second, got_w.third, got_w.mag)});
        end
      end
      if (in_valid_i && in_ready_i) begin
        // a full store drops the example, but a last flag still counts
        if (n_stored < STORE_DEPTH) begin
          feat_mem[n_stored] = feature_bits_i;
          label_mem[n_stored] = label_i;
          weight_mem[n_stored] = weight_i;
          n_stored++;
        end
        if (last_i) begin
          winners_q.insert(winners_q.size(), best_subset());
          n_stored = 0;
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_FEATURE_COUNT: fc_reg = cfg_wdata_i[FC_W-1:0];
          CFG_MAX_DEGREE:    md_reg = cfg_wdata_i[MD_W-1:0];
          default: ;
        endcase
      end
    end
    pending_o <= winners_q.size();
    errors_o <= errors;
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench top for the weighted parity subset search unit.
// Drives example batches and config writes; wpss_result_checker predicts and compares.
module tb;
  import wpss_pkg::*;

  // Slowest case: each of the up to ~100 random items a one-example batch of a full
  // degree 3 search over 696 subsets, plus the two overflow batches over a tiny
  // config and random stalls.
  localparam int CYCLE_LIMIT  = 4_000_000;
  localparam int IDLE_PCT     = 28;
  localparam int RANDOM_ITEMS = 600;
  localparam int SETTLE       = 16;
  // no idling on either side while the running random item count is in this window
  localparam int CALM_FROM    = 250;
  localparam int CALM_TO      = 360;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [FEAT_W-1:0]     feature_bits_i;
  logic                  label_i;
  logic [15:0]           weight_i;
  logic                  last_i;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [SIZE_W-1:0]     subset_size_o;
  logic [IDX_W-1:0]      feature_first_o;
  logic [IDX_W-1:0]      feature_second_o;
  logic [IDX_W-1:0]      feature_third_o;
  logic [MAG_OUT_W-1:0]  best_magnitude_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int          errors;
  int          pending;
  int unsigned cycles = 0;
  int          random_items = 0;
  logic        calm = 1'b0;

  weighted_parity_subset_search_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .feature_bits_i   (feature_bits_i),
    .label_i          (label_i),
    .weight_i         (weight_i),
    .last_i           (last_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .subset_size_o    (subset_size_o),
    .feature_first_o  (feature_first_o),
    .feature_second_o (feature_second_o),
    .feature_third_o  (feature_third_o),
    .best_magnitude_o (best_magnitude_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  wpss_result_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .feature_bits_i   (feature_bits_i),
    .label_i          (label_i),
    .weight_i         (weight_i),
    .last_i           (last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .subset_size_i    (subset_size_o),
    .feature_first_i  (feature_first_o),
    .feature_second_i (feature_second_o),
    .feature_third_i  (feature_third_o),
    .best_magnitude_i (best_magnitude_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .errors_o         (errors),
    .pending_o        (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hang guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: random back-pressure, none during the calm window
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // one example item; valid stays up with a steady payload until taken
  task automatic send_example(input logic [15:0] feat, input logic lbl,
                              input logic [15:0] wt, input logic lst);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    feature_bits_i <= feat;
    label_i <= lbl;
    weight_i <= wt;
    last_i <= lst;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // let every expected result come out and the unit fall idle
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // both registers; spare data bits above the degree field carry junk
  task automatic set_config(input logic [FC_W-1:0] fc, input logic [MD_W-1:0] deg);
    logic [CFG_DATA_W-1:0] junk;
    junk = $urandom;
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= CFG_FEATURE_COUNT;
    cfg_wdata_i <= fc;
    @(posedge clk_i);
    cfg_index_i <= CFG_MAX_DEGREE;
    cfg_wdata_i <= {junk[CFG_DATA_W-1:MD_W], deg};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random batch. Labels mostly follow the parity of a hidden subset so that the
  // winner lands anywhere; a noise share of labels is random. last closes it.
  task automatic send_batch(input int len, input bit counted);
    int          a;
    int          b;
    int          c;
    int          order;
    int          noise;
    logic [15:0] feat;
    logic [15:0] wt;
    logic        lbl;
    a = $urandom_range(0, 15);
    b = $urandom_range(0, 15);
    c = $urandom_range(0, 15);
    order = $urandom_range(1, 3);
    noise = $urandom_range(0, 40);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 19))
        0:       feat = 16'h0000;
        1:       feat = 16'hFFFF;
        default: feat = $urandom;
      endcase
      case ($urandom_range(0, 9))
        0:       wt = 16'h0000;
        1:       wt = 16'hFFFF;
        2:       wt = $urandom_range(0, 15);
        default: wt = $urandom;
      endcase
      lbl = feat[a];
      if (order >= 2) lbl ^= feat[b];
      if (order >= 3) lbl ^= feat[c];
      if ($urandom_range(0, 99) < noise) lbl = $urandom_range(0, 1);
      if (counted) begin
        random_items++;
        calm <= (random_items >= CALM_FROM) && (random_items < CALM_TO);
      end
      send_example(feat, lbl, wt, k == len - 1);
    end
  endtask

  initial begin
    logic [FC_W-1:0] fc;
    logic [MD_W-1:0] deg;
    int              len;
    bit              heavy;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    feature_bits_i <= '0;
    label_i <= 1'b0;
    weight_i <= '0;
    last_i <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_wdata_i <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, reset config first (16 features, degree 2).
    // All-zero batch: every sum ties at zero, the first subset wins.
    send_example(16'h0000, 1'b0, 16'h0000, 1'b1);
    send_example(16'hFFFF, 1'b1, 16'hFFFF, 1'b1);
    send_example(16'h8001, 1'b0, 16'h1234, 1'b0);
    send_example(16'h7FFE, 1'b1, 16'hFFFF, 1'b0);
    send_example(16'hAAAA, 1'b1, 16'h0001, 1'b1);
    // one feature, degree 3: sizes two and three have no subsets
    set_config(5'd1, 2'd3);
    send_example(16'h0001, 1'b0, 16'hFFFF, 1'b0);
    send_example(16'h0000, 1'b0, 16'h8000, 1'b1);
    // zero count and zero degree are both taken as one
    set_config(5'd0, 2'd0);
    send_example(16'h5555, 1'b1, 16'h00FF, 1'b1);
    // count above the feature width saturates; full degree 3 search
    set_config(5'd31, 2'd3);
    send_example(16'hF0F0, 1'b0, 16'hFFFF, 1'b0);
    send_example(16'h0F0F, 1'b1, 16'hFFFF, 1'b0);
    send_example(16'hFFFF, 1'b0, 16'h7FFF, 1'b1);
    // two features under degree 3
    set_config(5'd2, 2'd3);
    send_example(16'h0003, 1'b1, 16'h4000, 1'b0);
    send_example(16'h0001, 1'b0, 16'h4000, 1'b1);
    // top feature carries the signal
    set_config(5'd17, 2'd1);
    send_example(16'h8000, 1'b1, 16'hFFFF, 1'b0);
    send_example(16'h8000, 1'b1, 16'hFFFF, 1'b1);

    // Store exactly full, then overrun: the dropped last item still searches.
    set_config(5'($urandom_range(1, 4)), 2'd1);
    send_batch(EXAMPLES_DEF, 1'b1);
    send_batch(EXAMPLES_DEF + $urandom_range(1, 12), 1'b1);

    // Random phases: a config, then a few batches under it.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: begin fc = 5'd1;  deg = 2'd1; end
        1: begin fc = 5'd16; deg = 2'd3; end
        2: begin fc = 5'd31; deg = 2'd0; end
        3: begin fc = 5'd0;  deg = 2'd3; end
        default: begin
          fc = $urandom_range(0, 31);
          deg = $urandom_range(0, 3);
        end
      endcase
      set_config(fc, deg);
      // wide degree 3 searches are slow; keep their batches short
      heavy = (deg == 2'd3) && (fc >= 5'd10);
      repeat ($urandom_range(1, 5)) begin
        len = heavy ? $urandom_range(1, 6) : $urandom_range(1, 12);
        send_batch(len, 1'b1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
